>>> src/snhs_pkg.sv
`default_nettype none

package snhs_pkg;

    // Network size and derived widths
    localparam int MAX_NEURONS = 32;
    localparam int NW          = $clog2(MAX_NEURONS);
    localparam int CW          = NW + 1;
    localparam int SYN_DEPTH   = MAX_NEURONS * MAX_NEURONS;
    localparam int AW          = $clog2(SYN_DEPTH);
    localparam int TW          = 16 + $clog2(MAX_NEURONS);
    localparam int DVD_W       = 32;
    localparam int DVS_W       = TW + 1;

    // Fixed-point one in Q1.15
    localparam logic [16:0] Q15_ONE = 17'd32768;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_INJECT = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NEURONS   = 3'd0;
    localparam logic [2:0] CFG_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_CAP       = 3'd2;
    localparam logic [2:0] CFG_RATE      = 3'd3;
    localparam logic [2:0] CFG_DECAY     = 3'd4;
    localparam logic [2:0] CFG_FLOOR     = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [15:0] weight;
        logic [15:0] distance;
    } syn_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NEURON,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DLV_RD,
        ST_DLV_CHK,
        ST_DLV_DIVGO,
        ST_DLV_DIV,
        ST_DLV_POT,
        ST_DLV_WR,
        ST_DEC_RD,
        ST_DEC_CHK,
        ST_DEC_WR,
        ST_SETTLE
    } seq_state_t;

endpackage

`default_nettype wire

>>> src/snhs_syn_mem.sv
`default_nettype none

module snhs_syn_mem (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [snhs_pkg::AW-1:0] wr_addr,
    input  wire snhs_pkg::syn_entry_t    wr_data,
    input  wire logic [snhs_pkg::AW-1:0] rd_addr,
    output snhs_pkg::syn_entry_t         rd_data
);
    import snhs_pkg::*;

    syn_entry_t mem [SYN_DEPTH];
    syn_entry_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/snhs_div.sv
`default_nettype none

module snhs_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [snhs_pkg::DVD_W-1:0] dividend,
    input  wire logic [snhs_pkg::DVS_W-1:0] divisor,
    output snhs_pkg::div_stat_t             stat,
    output logic [snhs_pkg::DVD_W-1:0]      quotient
);
    import snhs_pkg::*;

    localparam int KW = $clog2(DVD_W);
    localparam logic [KW-1:0] LAST = KW'(DVD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic [DVD_W-1:0]  q_reg, q_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    trial;

    // Restoring divide, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, q_reg[DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

>>> src/spiking_net_hebbian_step.sv
`default_nettype none

// Spiking network stepper with Hebbian synapse update.
// Input channel (in_valid / in_stall) carries three request kinds: a synapse
// load, a charge inject and a time tick. Only a tick produces a result on the
// output channel (out_valid / out_stall): the fired and above-threshold masks.
// A transfer happens on a rising edge with valid high and stall low.
// Load and inject complete in the transfer itself. In a tick each of the N active
// neurons is visited in turn; a quiet neuron then reads each slot to an active
// target and decays each stored weight; a firing neuron first sums its weights,
// then for each stored synapse divides (skipped when its weight sum is zero)
// and writes back a strengthened weight. A settle pass then adds the buffers to
// the potentials. The single synapse memory port, one shared 16x17 multiplier
// and a bit-serial divider used once per delivering synapse set its pace.
// One item is worked on at a time; in_stall is high while a tick runs.
// A finished result waits in the output register; loads and injects are
// still taken meanwhile, but a new tick waits until the result is taken.
// After reset the synapse table is swept clear, one entry per cycle;
// no input transfer is taken during that sweep. Configuration
// writes (cfg_we, cfg_index, cfg_data) are taken at any time.
module spiking_net_hebbian_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [4:0]  source_index,
    input  wire logic [4:0]  target_index,
    input  wire logic        synapse_present,
    input  wire logic [15:0] weight_value,
    input  wire logic [15:0] distance_value,
    input  wire logic [15:0] charge_value,
    input  wire logic [31:0] spontaneous_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      fired_mask,
    output logic [31:0]      above_threshold_mask,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import snhs_pkg::*;

    // Configuration registers
    logic [5:0]  ncfg_reg;
    logic [15:0] thr_reg, cap_reg, rate_reg, decay_reg, floor_reg;

    // Sequencer and datapath state
    seq_state_t      state_reg, state_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [TW-1:0]   total_reg, total_next;
    logic [15:0]     w_reg, w_next;
    logic [15:0]     d_reg, d_next;
    logic [31:0]     spont_reg, spont_next;
    logic [31:0]     fired_reg, fired_next;
    logic [31:0]     above_reg, above_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     pot_reg [MAX_NEURONS];
    logic [15:0]     pot_next [MAX_NEURONS];
    logic [15:0]     buf_reg [MAX_NEURONS];
    logic [15:0]     buf_next [MAX_NEURONS];
    logic [32:0]     mul_reg;

    // Shared multiplier operands
    logic [15:0]     mul_a;
    logic [16:0]     mul_b;

    // Memory and divider hookup
    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    syn_entry_t      mem_wd, mem_rd;
    logic            div_start;
    div_stat_t       div_stat;
    logic [DVD_W-1:0] div_q;

    // Helpers
    logic            in_xfer, out_xfer;
    logic [CW-1:0]   count;
    logic            j_last, i_done, fire;
    logic [31:0]     bit_i, active_mask;
    logic [NW-1:0]   ii, jj;
    logic [16:0]     gap;
    logic [17:0]     pot_sum;
    logic [15:0]     pot_w, dec_w;
    logic [16:0]     dec_v;
    logic [16:0]     psum;

    function automatic logic [15:0] add_charge(input logic [15:0] b, input logic [15:0] c,
                                               input logic [15:0] cap);
        logic [16:0] s;
        s = {1'b0, b} + {1'b0, c};
        return (s > {1'b0, cap}) ? cap : s[15:0];
    endfunction

    assign count  = (32'(ncfg_reg) > MAX_NEURONS) ? CW'(MAX_NEURONS) : CW'(ncfg_reg);
    assign ii     = i_reg[NW-1:0];
    assign jj     = j_reg[NW-1:0];
    assign j_last = (CW'(j_reg + 1'b1) == count);
    assign i_done = (i_reg == count);
    assign bit_i  = (32'(i_reg) < 32) ? (32'd1 << i_reg) : '0;
    assign fire   = (pot_reg[ii] >= thr_reg) || ((spont_reg & bit_i) != '0);

    always_comb
    begin
        for (int k = 0; k < 32; k++)
        begin
            active_mask[k] = (k < int'(count));
        end
    end

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && (req_type == REQ_TICK));

    // Weight update arithmetic from the shared product
    assign gap     = (w_reg <= Q15_ONE[15:0]) ? (Q15_ONE - {1'b0, w_reg})
                                              : ({1'b0, w_reg} - Q15_ONE);
    assign pot_sum = {2'b0, w_reg} + mul_reg[32:15];
    assign pot_w   = (w_reg <= Q15_ONE[15:0])
                   ? ((pot_sum > 18'd65535) ? 16'hFFFF : pot_sum[15:0])
                   : (w_reg - mul_reg[30:15]);
    assign dec_v   = (mul_reg[32:15] > 18'd65535) ? 17'h0FFFF : mul_reg[31:15];
    assign dec_w   = (dec_v[15:0] < floor_reg) ? floor_reg : dec_v[15:0];
    assign psum    = {1'b0, pot_reg[ii]} + {1'b0, buf_reg[ii]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (clr_reg == AW'(SYN_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:      if (in_xfer && req_type == REQ_TICK) state_next = ST_NEURON;
            ST_NEURON:
            begin
                if (i_done)    state_next = ST_SETTLE;
                else if (fire) state_next = ST_SUM_RD;
                else           state_next = ST_DEC_RD;
            end
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = j_last ? ST_DLV_RD : ST_SUM_RD;
            ST_DLV_RD:    state_next = ST_DLV_CHK;
            ST_DLV_CHK:
            begin
                if (mem_rd.valid) state_next = ST_DLV_DIVGO;
                else              state_next = j_last ? ST_NEURON : ST_DLV_RD;
            end
            ST_DLV_DIVGO: state_next = (total_reg != '0) ? ST_DLV_DIV : ST_DLV_POT;
            ST_DLV_DIV:   if (div_stat.done) state_next = ST_DLV_POT;
            ST_DLV_POT:   state_next = ST_DLV_WR;
            ST_DLV_WR:    state_next = j_last ? ST_NEURON : ST_DLV_RD;
            ST_DEC_RD:    state_next = ST_DEC_CHK;
            ST_DEC_CHK:
            begin
                if (mem_rd.valid) state_next = ST_DEC_WR;
                else              state_next = j_last ? ST_NEURON : ST_DEC_RD;
            end
            ST_DEC_WR:    state_next = j_last ? ST_NEURON : ST_DEC_RD;
            ST_SETTLE:    if (i_done) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        spont_next     = spont_reg;
        fired_next     = fired_reg;
        above_next     = above_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        pot_next       = pot_reg;
        buf_next       = buf_reg;
        mul_a          = w_reg;
        mul_b          = gap;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = AW'(32'(ii) * MAX_NEURONS + 32'(jj));
        mem_ra         = AW'(32'(ii) * MAX_NEURONS + 32'(jj));
        mem_wd         = '{valid: 1'b1, weight: pot_w, distance: d_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            mem_we = (32'(source_index) < MAX_NEURONS)
                                  && (32'(target_index) < MAX_NEURONS);
                            mem_wa = AW'(32'(source_index) * MAX_NEURONS
                                         + 32'(target_index));
                            mem_wd = '{valid: synapse_present, weight: weight_value,
                                       distance: distance_value};
                        end
                        REQ_INJECT:
                        begin
                            if (32'(target_index) < MAX_NEURONS)
                            begin
                                buf_next[NW'(target_index)] =
                                    add_charge(buf_reg[NW'(target_index)], charge_value,
                                               cap_reg);
                            end
                        end
                        REQ_TICK:
                        begin
                            i_next     = '0;
                            spont_next = spontaneous_mask;
                            fired_next = '0;
                            above_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NEURON:
            begin
                j_next     = '0;
                total_next = '0;
                if (i_done)
                begin
                    i_next = '0;
                end
                else if (fire)
                begin
                    pot_next[ii] = '0;
                    fired_next   = fired_reg | bit_i;
                end
            end
            ST_SUM_ACC:
            begin
                if (mem_rd.valid)
                begin
                    total_next = total_reg + TW'(mem_rd.weight);
                end
                j_next = j_last ? '0 : CW'(j_reg + 1'b1);
            end
            ST_DLV_CHK, ST_DEC_CHK:
            begin
                w_next = mem_rd.weight;
                d_next = mem_rd.distance;
                mul_a  = mem_rd.weight;
                mul_b  = (state_reg == ST_DLV_CHK) ? {1'b0, mem_rd.distance}
                                                   : {1'b0, decay_reg};
                if (!mem_rd.valid)
                begin
                    j_next = j_last ? '0 : CW'(j_reg + 1'b1);
                    if (j_last) i_next = CW'(i_reg + 1'b1);
                end
            end
            ST_DLV_DIVGO:
            begin
                div_start = (total_reg != '0);
            end
            ST_DLV_DIV:
            begin
                if (div_stat.done)
                begin
                    buf_next[jj] = add_charge(buf_reg[jj], div_q[15:0], cap_reg);
                end
            end
            ST_DLV_POT:
            begin
                mul_a = rate_reg;
                mul_b = gap;
            end
            ST_DLV_WR, ST_DEC_WR:
            begin
                mem_we = 1'b1;
                mem_wd = '{valid: 1'b1,
                           weight: (state_reg == ST_DLV_WR) ? pot_w : dec_w,
                           distance: d_reg};
                j_next = j_last ? '0 : CW'(j_reg + 1'b1);
                if (j_last) i_next = CW'(i_reg + 1'b1);
            end
            ST_SETTLE:
            begin
                if (i_done)
                begin
                    out_valid_next = 1'b1;
                end
                else
                begin
                    pot_next[ii] = (psum > 17'd65535) ? 16'hFFFF : psum[15:0];
                    buf_next[ii] = '0;
                    if (pot_next[ii] > thr_reg) above_next = above_reg | bit_i;
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            default: ;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            fired_reg     <= '0;
            above_reg     <= '0;
            ncfg_reg      <= 6'd32;
            thr_reg       <= 16'd13107;
            cap_reg       <= 16'd32768;
            rate_reg      <= 16'd26214;
            decay_reg     <= 16'd26214;
            floor_reg     <= 16'd1;
            for (int k = 0; k < MAX_NEURONS; k++)
            begin
                pot_reg[k] <= '0;
                buf_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            fired_reg     <= fired_next;
            above_reg     <= above_next;
            pot_reg       <= pot_next;
            buf_reg       <= buf_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NEURONS:   ncfg_reg  <= cfg_data[5:0];
                    CFG_THRESHOLD: thr_reg   <= cfg_data;
                    CFG_CAP:       cap_reg   <= cfg_data;
                    CFG_RATE:      rate_reg  <= cfg_data;
                    CFG_DECAY:     decay_reg <= cfg_data;
                    CFG_FLOOR:     floor_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        w_reg     <= w_next;
        d_reg     <= d_next;
        spont_reg <= spont_next;
        mul_reg   <= 33'(mul_a) * 33'(mul_b);
    end

    snhs_syn_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    snhs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg[31:0]),
        .divisor  ({total_reg, 1'b0}),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign out_valid            = out_valid_reg;
    assign fired_mask           = fired_reg;
    assign above_threshold_mask = above_reg;

    // The divider is only started with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (total_reg != '0))
        else $error("divider started with zero total weight");

    // No table write while a division is in flight
    a_no_write_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !mem_we)
        else $error("synapse write during division");

    // Reported firings lie within the active neurons
    a_fired_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((fired_reg & ~active_mask) == '0))
        else $error("inactive neuron reported as fired");

endmodule

`default_nettype wire

>>> tb/spiking_net_hebbian_step_test.sv
`timescale 1ns / 1ps

module spiking_net_hebbian_step_test;
    import snhs_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code
    localparam int STEP_REQ  = 0;
    localparam int STEP_CFG  = 1;
    localparam int STEP_HOLD = 2;
    localparam int QUIET_CYCLES = 12;
    localparam int STALL_LIMIT  = 250000;

    typedef struct {
        int          kind;
        logic [1:0]  req;
        logic [4:0]  src;
        logic [4:0]  tgt;
        logic        pres;
        logic [15:0] wgt;
        logic [15:0] dst;
        logic [15:0] chg;
        logic [31:0] spont;
        logic [2:0]  idx;
        logic [15:0] val;
    } step_t;

    typedef struct {
        logic [31:0] fired;
        logic [31:0] above;
    } masks_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_LOAD;
    logic [4:0]  source_index = '0;
    logic [4:0]  target_index = '0;
    logic        synapse_present = 1'b0;
    logic [15:0] weight_value = '0;
    logic [15:0] distance_value = '0;
    logic [15:0] charge_value = '0;
    logic [31:0] spontaneous_mask = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] fired_mask;
    logic [31:0] above_threshold_mask;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_NEURONS;
    logic [15:0] cfg_data = '0;

    spiking_net_hebbian_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .source_index(source_index),
        .target_index(target_index), .synapse_present(synapse_present),
        .weight_value(weight_value), .distance_value(distance_value),
        .charge_value(charge_value), .spontaneous_mask(spontaneous_mask),
        .out_valid(out_valid), .out_stall(out_stall),
        .fired_mask(fired_mask), .above_threshold_mask(above_threshold_mask),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Network mirror: configuration, synapse table, potentials, buffers
    logic [5:0]  net_count = 6'd32;
    logic [15:0] net_thresh = 16'd13107;
    logic [15:0] net_cap = 16'd32768;
    logic [15:0] net_rate = 16'd26214;
    logic [15:0] net_decay = 16'd26214;
    logic [15:0] net_floor = 16'd1;
    bit          syn_on [SYN_DEPTH];
    logic [15:0] syn_wgt [SYN_DEPTH];
    logic [15:0] syn_dst [SYN_DEPTH];
    logic [15:0] potential [MAX_NEURONS];
    logic [15:0] inbox [MAX_NEURONS];

    step_t  pending [$];
    masks_t tick_masks [$];
    int     mismatches = 0;
    int     sent_count = 0;
    int     send_idle_pct = 7;
    int     recv_stall_pct = 85;
    int     quiet = 0;
    int     idle_cycles = 0;
    logic   took = 1'b0;

    initial begin
        for (int i = 0; i < MAX_NEURONS; i++) begin
            potential[i] = '0;
            inbox[i] = '0;
        end
    end

    function automatic logic [15:0] sat16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void charge_in(int n, longint unsigned q);
        longint unsigned s;
        s = inbox[n] + q;
        if (s > net_cap) s = net_cap;
        inbox[n] = s[15:0];
    endfunction

    function automatic logic [15:0] strengthen(logic [15:0] w);
        longint unsigned r;
        r = net_rate;
        if (w <= 16'd32768)
            return sat16(w + ((r * (32768 - w)) >> 15));
        return w - 16'(((r * (w - 32768)) >> 15));
    endfunction

    function automatic logic [15:0] weaken(logic [15:0] w);
        logic [15:0] v;
        longint unsigned p;
        p = w;
        v = sat16((p * net_decay) >> 15);
        if (v < net_floor) v = net_floor;
        return v;
    endfunction

    // One network step; returns the fired and above-threshold masks
    function automatic masks_t step_network(logic [31:0] spont);
        masks_t m;
        int cnt, k;
        longint unsigned total, q;
        m.fired = '0;
        m.above = '0;
        cnt = (net_count < MAX_NEURONS) ? net_count : MAX_NEURONS;
        for (int i = 0; i < cnt; i++) begin
            if (potential[i] >= net_thresh || spont[i]) begin
                total = 0;
                for (int j = 0; j < cnt; j++)
                    if (syn_on[i*MAX_NEURONS + j]) total += syn_wgt[i*MAX_NEURONS + j];
                for (int j = 0; j < cnt; j++) begin
                    k = i*MAX_NEURONS + j;
                    if (syn_on[k]) begin
                        if (total != 0) begin
                            q = (longint'(syn_wgt[k]) * syn_dst[k]) / (total * 2);
                            charge_in(j, q);
                        end
                        syn_wgt[k] = strengthen(syn_wgt[k]);
                    end
                end
                potential[i] = '0;
                m.fired[i] = 1'b1;
            end else begin
                for (int j = 0; j < cnt; j++) begin
                    k = i*MAX_NEURONS + j;
                    if (syn_on[k]) syn_wgt[k] = weaken(syn_wgt[k]);
                end
            end
        end
        for (int i = 0; i < cnt; i++) begin
            potential[i] = sat16(longint'(potential[i]) + inbox[i]);
            inbox[i] = '0;
            if (potential[i] > net_thresh) m.above[i] = 1'b1;
        end
        return m;
    endfunction

    // Monitor: predicts on each input transfer, checks each output transfer
    always @(posedge clk) begin
        masks_t got;
        masks_t want;
        int     k;
        if (rst_n) begin
            took <= in_valid && !in_stall;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NEURONS:   net_count = cfg_data[5:0];
                    CFG_THRESHOLD: net_thresh = cfg_data;
                    CFG_CAP:       net_cap = cfg_data;
                    CFG_RATE:      net_rate = cfg_data;
                    CFG_DECAY:     net_decay = cfg_data;
                    CFG_FLOOR:     net_floor = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                k = source_index * MAX_NEURONS + target_index;
                case (req_type)
                    REQ_LOAD: begin
                        syn_on[k] = synapse_present;
                        if (synapse_present) begin
                            syn_wgt[k] = weight_value;
                            syn_dst[k] = distance_value;
                        end
                    end
                    REQ_INJECT: charge_in(target_index, charge_value);
                    REQ_TICK:   tick_masks = {tick_masks, step_network(spontaneous_mask)};
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                got.fired = fired_mask;
                got.above = above_threshold_mask;
                if (tick_masks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: fired %h above %h", got.fired, got.above);
                end else begin
                    want = tick_masks.pop_front();
                    if (got.fired !== want.fired) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("fired_mask: expected %h got %h", want.fired, got.fired);
                    end
                    if (got.above !== want.above) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("above_threshold_mask: expected %h got %h",
                                     want.above, got.above);
                    end
                end
            end
            // watchdog on cycles without any transfer
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Driver: one request per transfer, config writes and holds only when idle
    always @(negedge clk) begin
        logic  v_n, we_n, drain_ok;
        step_t it;
        v_n = in_valid;
        we_n = 1'b0;
        if (rst_n) begin
            drain_ok = (tick_masks.size() == 0) && (!in_valid || took);
            quiet = drain_ok ? quiet + 1 : 0;
            if (sent_count < 180) begin
                send_idle_pct = 7;
                recv_stall_pct = 85;
            end else if (sent_count < 360) begin
                send_idle_pct = 85;
                recv_stall_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (in_valid && !took) begin
                // payload held until taken
            end else if (pending.size() == 0) begin
                v_n = 1'b0;
            end else if (pending[0].kind != STEP_REQ) begin
                v_n = 1'b0;
                if (quiet >= QUIET_CYCLES) begin
                    it = pending.pop_front();
                    if (it.kind == STEP_CFG) begin
                        we_n = 1'b1;
                        cfg_index <= it.idx;
                        cfg_data <= it.val;
                    end
                end
            end else if ($urandom_range(99) < send_idle_pct) begin
                v_n = 1'b0;
            end else begin
                it = pending.pop_front();
                v_n = 1'b1;
                sent_count++;
                req_type <= it.req;
                source_index <= it.src;
                target_index <= it.tgt;
                synapse_present <= it.pres;
                weight_value <= it.wgt;
                distance_value <= it.dst;
                charge_value <= it.chg;
                spontaneous_mask <= it.spont;
            end
        end
        in_valid <= v_n;
        cfg_we <= we_n;
    end

    task automatic push_req(logic [1:0] r, logic [4:0] s, logic [4:0] t, logic p,
                            logic [15:0] w, logic [15:0] d, logic [15:0] c,
                            logic [31:0] sp);
        step_t it;
        it.kind = STEP_REQ;
        it.req = r; it.src = s; it.tgt = t; it.pres = p;
        it.wgt = w; it.dst = d; it.chg = c; it.spont = sp;
        it.idx = '0; it.val = '0;
        pending = {pending, it};
    endtask

    task automatic push_cfg(logic [2:0] idx, logic [15:0] val);
        step_t it;
        it = '{default: '0};
        it.kind = STEP_CFG;
        it.idx = idx;
        it.val = val;
        pending = {pending, it};
    endtask

    task automatic push_hold();
        step_t it;
        it = '{default: '0};
        it.kind = STEP_HOLD;
        pending = {pending, it};
    endtask

    // Random segment: loads mostly within the active set, injects, ticks, some noise
    task automatic random_segment(int n, int len);
        int    roll;
        logic [31:0] live;
        live = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
        if (n == 0) live = 32'd1;
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            if (roll < 35)
                push_req(REQ_LOAD,
                         ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(n > 0 ? n-1 : 0)),
                         ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(n > 0 ? n-1 : 0)),
                         $urandom_range(99) < 85,
                         ($urandom_range(15) == 0) ? 16'd32768 : 16'($urandom_range(32768)),
                         ($urandom_range(15) == 0) ? 16'd32768 : 16'($urandom_range(32768)),
                         16'($urandom), '0);
            else if (roll < 68)
                push_req(REQ_INJECT, 5'($urandom), 5'($urandom_range(n > 0 ? n-1 : 0)),
                         1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), '0);
            else if (roll < 95)
                push_req(REQ_TICK, 5'($urandom), 5'($urandom), 1'($urandom), 16'($urandom),
                         16'($urandom),
                         16'($urandom), ($urandom & $urandom & $urandom) & live);
            else
                push_req(REQ_NONE, 5'($urandom), 5'($urandom), 1'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), $urandom);
        end
    endtask

    initial begin
        int n;
        // directed: extremes, every request, zero-weight fanout, saturation
        push_req(REQ_LOAD, 5'd0, 5'd1, 1'b1, 16'd32768, 16'd32768, '0, '0);
        push_req(REQ_LOAD, 5'd31, 5'd0, 1'b1, 16'd0, 16'd0, '0, '0);
        push_req(REQ_LOAD, 5'd1, 5'd31, 1'b1, 16'd1, 16'd32768, '0, '0);
        push_req(REQ_INJECT, 5'd0, 5'd1, 1'b0, '0, '0, 16'hFFFF, '0);
        push_req(REQ_INJECT, 5'd0, 5'd1, 1'b0, '0, '0, 16'hFFFF, '0);
        push_req(REQ_INJECT, 5'd0, 5'd31, 1'b0, '0, '0, 16'd0, '0);
        push_req(REQ_NONE, 5'd31, 5'd31, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'h8000_0001);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'h0);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
        push_req(REQ_LOAD, 5'd0, 5'd1, 1'b0, '0, '0, '0, '0);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'h0000_0002);
        // lowered cap below an already charged buffer, zero active neurons
        push_req(REQ_INJECT, '0, 5'd2, 1'b0, '0, '0, 16'd40000, '0);
        push_hold();
        push_cfg(CFG_CAP, 16'd100);
        push_req(REQ_INJECT, '0, 5'd2, 1'b0, '0, '0, 16'd5, '0);
        push_cfg(CFG_NEURONS, 16'd0);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
        push_cfg(CFG_NEURONS, 16'd63);
        push_cfg(CFG_THRESHOLD, 16'd0);
        push_cfg(CFG_RATE, 16'd32768);
        push_cfg(CFG_DECAY, 16'd0);
        push_cfg(CFG_FLOOR, 16'd32768);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'h0);
        push_cfg(CFG_THRESHOLD, 16'hFFFF);
        push_cfg(CFG_CAP, 16'hFFFF);
        push_cfg(CFG_RATE, 16'd0);
        push_cfg(CFG_DECAY, 16'd32768);
        push_cfg(CFG_FLOOR, 16'd0);
        push_req(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, 32'h5555_AAAA);

        // random phases, most with a small active set
        for (int seg = 0; seg < 13; seg++) begin
            case ($urandom_range(9))
                0:       n = 32;
                1:       n = $urandom_range(1) ? 1 : 0;
                2:       n = $urandom_range(33, 63);
                default: n = $urandom_range(2, 8);
            endcase
            push_cfg(CFG_NEURONS, 16'(n));
            push_cfg(CFG_THRESHOLD, ($urandom_range(7) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(20000)));
            push_cfg(CFG_CAP, ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom));
            push_cfg(CFG_RATE, 16'($urandom_range(32768)));
            push_cfg(CFG_DECAY, 16'($urandom_range(32768)));
            push_cfg(CFG_FLOOR, ($urandom_range(3) == 0) ? 16'($urandom_range(32768))
                                                        : 16'($urandom_range(8)));
            random_segment((n > 32) ? 32 : n, (n >= 32) ? 24 : 44);
            if (seg % 4 == 1) push_hold();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending.size() == 0);
        wait (!in_valid);
        wait (tick_masks.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
